// ----- hdl/scet_pkg.sv -----
// Shared types, codes and saturating helpers for the subinterval cost envelope table.
// No dependencies; imported by every module under hdl.
package scet_pkg;

	typedef logic signed [31:0] q16_t;

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_PRUNE = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	localparam logic REG_BEGIN = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef struct packed {
		q16_t start;
		q16_t finish;
		q16_t cost;
	} span_t;

	typedef struct packed {
		logic finite;
		q16_t cost;
	} cost_t;

	// cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	function automatic q16_t sat34(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -34'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- hdl/scet_cell.sv -----
// One table slot: holds one entry and hands it to the cell below when the row shifts.
// Depends on scet_pkg.
module scet_cell #(
	parameter int NW = 16
) (
	input  logic                clk,
	input  scet_pkg::cell_ctl_t ctl,
	input  scet_pkg::span_t     nxt_span,
	input  logic [NW-1:0]       nxt_node,
	input  scet_pkg::span_t     ld_span,
	input  logic [NW-1:0]       ld_node,
	output scet_pkg::span_t     span,
	output logic [NW-1:0]       node
);
	import scet_pkg::*;

	span_t         span_q;
	logic [NW-1:0] node_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			span_q <= ld_span;
			node_q <= ld_node;
		end else if (ctl.shift) begin
			span_q <= nxt_span;
			node_q <= nxt_node;
		end
	end

	assign span = span_q;
	assign node = node_q;
endmodule

// ----- hdl/scet_eval.sv -----
// Cost of one entry at a given time: infinite past its end, base cost inside,
// base cost plus lead time before it (saturated). Depends on scet_pkg.
module scet_eval (
	input  scet_pkg::span_t span,
	input  scet_pkg::q16_t  t,
	output scet_pkg::cost_t res
);
	import scet_pkg::*;

	logic signed [33:0] sum;

	always_comb begin
		sum = 34'(span.cost) + 34'(span.start) - 34'(t);
		res.finite = (t <= span.finish);
		if (t >= span.start)
			res.cost = span.cost;
		else
			res.cost = sat34(sum);
	end
endmodule

// ----- hdl/subinterval_cost_envelope_table.sv -----
// Top level of the subinterval cost envelope table: sequencer, row of entry cells,
// two cost evaluators and the result register. Depends on scet_pkg, scet_cell, scet_eval.
//
// channel | dir | fields (low bit up)
// s_*     | in  | tuser: func[1:0]; tdata: query_time, span_start, span_finish,
//         |     |   base_cost, time_shift, node_handle (176 bits)
// m_*     | out | tdata: min_cost, cost_infinite, best_node, node_valid, added,
//         |     |   table_full, entry_total, zero fill (64 bits)
// cfg_*   | in  | write: 0 interval_begin, 1 interval_end
//
// Each request is taken in the idle state; the scan state then rotates the row of
// cells once past the head evaluators, one entry a cycle, compacting itself on a
// prune as it goes (no scan with an empty table), and the finishing state loads
// the result register. A new request is taken in idle even while the previous
// result still waits on m_tready; the finishing step waits for the result
// register to free up. Reset empties the table and restores the window
// registers; the entry contents themselves are not cleared.
module subinterval_cost_envelope_table #(
	parameter int MAX_ENTRIES = 16,
	parameter int NODE_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [175:0] s_tdata,  // query_time, span_start, span_finish, base_cost,
	                               // time_shift, node_handle
	input  logic [1:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // min_cost, cost_infinite, best_node, node_valid,
	                               // added, table_full, entry_total
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import scet_pkg::*;

	localparam int NW   = (NODE_BITS < 16) ? NODE_BITS : 16;
	localparam int CntW = $clog2(MAX_ENTRIES + 1);

	// window registers
	q16_t win_begin_q, win_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_begin_q <= 32'sd0;
			win_end_q   <= 32'sh7FFFFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEGIN: win_begin_q <= cfg_data;
				REG_END:   win_end_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// request fields
	q16_t          in_t, in_ss, in_sf, in_cost, in_shift;
	logic [15:0]   in_node;
	assign in_t     = s_tdata[31:0];
	assign in_ss    = s_tdata[63:32];
	assign in_sf    = s_tdata[95:64];
	assign in_cost  = s_tdata[127:96];
	assign in_shift = s_tdata[159:128];
	assign in_node  = s_tdata[175:160];

	// shifted and clipped add interval
	q16_t clip_s, clip_e, sh_s, sh_e;
	always_comb begin
		sh_s   = sat34(34'(in_ss) - 34'(in_shift));
		sh_e   = sat34(34'(in_sf) - 34'(in_shift));
		clip_s = (sh_s < win_begin_q) ? win_begin_q : sh_s;
		clip_e = (sh_e > win_end_q) ? win_end_q : sh_e;
	end

	state_t        state_q, state_nx;
	func_t         func_q;
	q16_t          t_q, s_q, e_q, h_q;
	logic [NW-1:0] node_q;
	logic          span_ok_q;
	logic [CntW-1:0] count_q, j_q, k_q;

	// accumulators: lane 0 at query time or add start, lane 1 at add end
	logic          fin0_q, fin1_q;
	q16_t          best0_q, best1_q;
	logic [NW-1:0] bnode0_q;

	logic          m_tvalid_q;
	logic [63:0]   m_tdata_q;

	logic acc_in, last_scan, out_free;
	assign acc_in    = s_tvalid && s_tready;
	assign last_scan = (j_q == count_q - CntW'(1));
	assign out_free  = !m_tvalid_q || m_tready;

	// row of cells; cell 0 is the head
	span_t         c_span [MAX_ENTRIES];
	logic [NW-1:0] c_node [MAX_ENTRIES];
	span_t         ld_span;
	logic [NW-1:0] ld_node;
	cost_t         ev0, ev1;
	logic          keep;
	logic [CntW-1:0] wr_pos;
	logic          add_ok, add_take;

	always_comb begin
		keep   = (func_q != FUNC_PRUNE) || (c_span[0].finish >= t_q);
		wr_pos = count_q - CntW'(1) - j_q + k_q;
		if (state_q == ST_SCAN) begin
			ld_span = c_span[0];
			ld_node = c_node[0];
		end else begin
			ld_span = '{start: s_q, finish: e_q, cost: h_q};
			ld_node = node_q;
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;
		always_comb begin
			ctl.shift = (state_q == ST_SCAN);
			if (state_q == ST_SCAN)
				ctl.load = keep && (wr_pos == CntW'(i));
			else
				ctl.load = (state_q == ST_FIN) && out_free && add_take &&
				           (count_q == CntW'(i));
		end
		scet_cell #(.NW(NW)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.nxt_span (c_span[(i + 1) % MAX_ENTRIES]),
			.nxt_node (c_node[(i + 1) % MAX_ENTRIES]),
			.ld_span  (ld_span),
			.ld_node  (ld_node),
			.span     (c_span[i]),
			.node     (c_node[i])
		);
	end

	scet_eval u_ev0 (.span(c_span[0]), .t((func_q == FUNC_ADD) ? s_q : t_q), .res(ev0));
	scet_eval u_ev1 (.span(c_span[0]), .t(e_q), .res(ev1));

	// add decision at finish; an empty table accepts anything non-empty
	assign add_ok = span_ok_q && ((count_q == '0) || !fin0_q || (h_q < best0_q) ||
	                              !fin1_q || (h_q < best1_q));
	assign add_take = (func_q == FUNC_ADD) && add_ok && (count_q < CntW'(MAX_ENTRIES));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in) state_nx = (count_q == '0) ? ST_FIN : ST_SCAN;
			ST_SCAN: if (last_scan) state_nx = ST_FIN;
			ST_FIN:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (acc_in) begin
			func_q    <= func_t'(s_tuser);
			t_q       <= in_t;
			s_q       <= clip_s;
			e_q       <= clip_e;
			h_q       <= in_cost;
			node_q    <= in_node[NW-1:0];
			span_ok_q <= (clip_s <= clip_e);
		end
	end

	// scan counters and minimum tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			fin0_q  <= 1'b0;
			fin1_q  <= 1'b0;
		end else begin
			if (acc_in) begin
				j_q    <= '0;
				k_q    <= '0;
				fin0_q <= 1'b0;
				fin1_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				j_q <= j_q + CntW'(1);
				if (keep)
					k_q <= k_q + CntW'(1);
				if (ev0.finite && (!fin0_q || ev0.cost < best0_q))
					fin0_q <= 1'b1;
				if (ev1.finite && (!fin1_q || ev1.cost < best1_q))
					fin1_q <= 1'b1;
			end else if (state_q == ST_FIN && out_free) begin
				if (func_q == FUNC_PRUNE)
					count_q <= k_q;
				else if (add_take)
					count_q <= count_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			if (ev0.finite && (!fin0_q || ev0.cost < best0_q)) begin
				best0_q  <= ev0.cost;
				bnode0_q <= c_node[0];
			end
			if (ev1.finite && (!fin1_q || ev1.cost < best1_q))
				best1_q <= ev1.cost;
		end
	end

	// result
	logic [CntW-1:0] new_count;
	logic          in_win, r_inf, r_nv;
	q16_t          r_cost;
	logic [15:0]   r_node;
	always_comb begin
		if (func_q == FUNC_PRUNE)
			new_count = k_q;
		else if (add_take)
			new_count = count_q + CntW'(1);
		else
			new_count = count_q;
		in_win = (t_q >= win_begin_q) && (t_q <= win_end_q);
		r_inf  = 1'b0;
		r_nv   = 1'b0;
		r_cost = '0;
		r_node = '0;
		if (func_q == FUNC_QUERY) begin
			if (!in_win)
				r_inf = 1'b1;
			else if (count_q != '0) begin
				if (fin0_q) begin
					r_cost = best0_q;
					r_nv   = 1'b1;
					r_node = 16'(bnode0_q);
				end else
					r_inf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_FIN && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free)
			m_tdata_q <= {7'd0, 5'(new_count),
			              (func_q == FUNC_ADD) && add_ok && !add_take,
			              add_take, r_nv, r_node, r_inf, r_cost};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

// ----- verif/tb_subinterval_cost_envelope_table.sv -----
// Self-checking bench for subinterval_cost_envelope_table: directed and random
// add/prune/query/no-op requests checked against a behavioural envelope predictor.
// Depends on scet_pkg and the DUT only.
module tb_subinterval_cost_envelope_table;
	import scet_pkg::*;

	localparam int DEPTH = 16;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 400000;

	// one request: func plus the packed payload
	typedef struct {
		func_t       op;
		logic [175:0] payload;
	} request_t;

	typedef struct {
		logic [31:0] cost;
		logic        inf;
		logic [15:0] node;
		logic        nvalid;
		logic        added;
		logic        full;
		logic [4:0]  total;
	} outcome_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [175:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	subinterval_cost_envelope_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	longint   win_lo, win_hi;
	longint   tab_start[DEPTH];
	longint   tab_finish[DEPTH];
	longint   tab_cost[DEPTH];
	logic [15:0] tab_node[DEPTH];
	int       tab_count;

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];
	outcome_t want_o;
	int       errors = 0;
	int       cycles = 0;
	int       results_seen = 0;
	int       sent_total = 0;
	int       queries_finite = 0, adds_stored = 0, adds_dropped = 0;

	// driver pacing
	int       gap_left, burst_left;
	int       gap_nx, burst_nx;

	// long hold-off on the result side, counted here
	int       holdoff_left;
	bit       holdoff_armed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > QMAX)
			return QMAX;
		if (v < QMIN)
			return QMIN;
		return v;
	endfunction

	// envelope minimum at time t; returns 0 when infinite
	function automatic bit envelope_at(input longint t, output longint cost,
			output bit has_node, output logic [15:0] node);
		bit finite;
		longint c;
		finite = 0;
		cost = 0;
		has_node = 0;
		node = '0;
		if (t < win_lo || t > win_hi)
			return 0;
		if (tab_count == 0)
			return 1;
		for (int i = 0; i < tab_count; i++) begin
			if (t <= tab_finish[i]) begin
				c = (t >= tab_start[i]) ? tab_cost[i] :
					clamp32(tab_cost[i] + tab_start[i] - t);
				if (!finite || c < cost) begin
					finite = 1;
					cost = c;
					has_node = 1;
					node = tab_node[i];
				end
			end
		end
		return finite;
	endfunction

	// apply one request to the predictor, return its result
	function automatic outcome_t envelope_step(input request_t r);
		outcome_t o;
		longint t, s, e, h, c;
		bit hn, ok;
		logic [15:0] nd;
		int k;
		o = '{default: '0};
		t = longint'($signed(r.payload[31:0]));
		case (r.op)
			FUNC_ADD: begin
				h = longint'($signed(r.payload[127:96]));
				s = clamp32(longint'($signed(r.payload[63:32])) -
					longint'($signed(r.payload[159:128])));
				e = clamp32(longint'($signed(r.payload[95:64])) -
					longint'($signed(r.payload[159:128])));
				if (s < win_lo)
					s = win_lo;
				if (e > win_hi)
					e = win_hi;
				if (s <= e) begin
					ok = (tab_count == 0);
					if (!ok) begin
						if (!envelope_at(s, c, hn, nd) || h < c)
							ok = 1;
						else if (!envelope_at(e, c, hn, nd) || h < c)
							ok = 1;
					end
					if (ok) begin
						if (tab_count >= DEPTH) begin
							o.full = 1;
						end else begin
							tab_start[tab_count] = s;
							tab_finish[tab_count] = e;
							tab_cost[tab_count] = h;
							tab_node[tab_count] = r.payload[175:160];
							tab_count++;
							o.added = 1;
						end
					end
				end
			end
			FUNC_PRUNE: begin
				k = 0;
				for (int i = 0; i < tab_count; i++) begin
					if (tab_finish[i] >= t) begin
						tab_start[k] = tab_start[i];
						tab_finish[k] = tab_finish[i];
						tab_cost[k] = tab_cost[i];
						tab_node[k] = tab_node[i];
						k++;
					end
				end
				tab_count = k;
			end
			FUNC_QUERY: begin
				if (envelope_at(t, c, hn, nd)) begin
					o.cost = c[31:0];
					o.nvalid = hn;
					o.node = hn ? nd : '0;
				end else begin
					o.inf = 1;
				end
			end
			default: ;
		endcase
		o.total = tab_count[4:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what, got, want);
	endtask

	// stimulus helpers
	function automatic longint pick_time();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return longint'($signed($urandom()));
		else if (sel == 1)
			return QMAX - longint'($urandom_range(0, 40));
		else if (sel == 2)
			return QMIN + longint'($urandom_range(0, 40));
		else
			return longint'($urandom_range(0, 4000)) - 500;
	endfunction

	task automatic push_req(input func_t op, input longint t, input longint ss,
			input longint sf, input longint hc, input longint sh, input logic [15:0] nd);
		request_t r;
		r.op = op;
		r.payload = {nd, sh[31:0], hc[31:0], sf[31:0], ss[31:0], t[31:0]};
		pending_reqs.push_back(r);
	endtask

	task automatic push_random(input bit wide);
		int unsigned sel;
		longint t, ss, sf, hc, sh;
		func_t op;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			op = FUNC_ADD;
		else if (sel < 60)
			op = FUNC_PRUNE;
		else if (sel < 95)
			op = FUNC_QUERY;
		else
			op = FUNC_NOP;
		t  = pick_time();
		ss = pick_time();
		sf = ss + longint'($urandom_range(0, 1500)) - 200;
		hc = ($urandom_range(0, 9) == 0) ? longint'($signed($urandom())) :
			longint'($urandom_range(0, 3000)) - 500;
		sh = ($urandom_range(0, 9) == 0) ? longint'($signed($urandom())) :
			longint'($urandom_range(0, 300)) - 100;
		if (wide && $urandom_range(0, 1) == 1) begin
			t  = longint'($signed($urandom()));
			ss = longint'($signed($urandom()));
			sf = ss + longint'($signed($urandom()));
		end
		push_req(op, t, ss, sf, hc, sh, 16'($urandom()));
	endtask

	// wait until nothing is queued, offered or awaiting its result
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_outcomes.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input longint value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[31:0];
		if (idx == REG_BEGIN)
			win_lo = longint'($signed(value[31:0]));
		else
			win_hi = longint'($signed(value[31:0]));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			gap_nx = gap_left;
			burst_nx = burst_left;
			if (s_tvalid && s_tready) begin
				expected_outcomes.push_back(envelope_step(pending_reqs.pop_front()));
				sent_total++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_nx > 0 || pending_reqs.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_nx > 0)
						gap_nx--;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_reqs[0].payload;
					s_tuser  <= pending_reqs[0].op;
					if (burst_nx <= 1) begin
						burst_nx = $urandom_range(1, 10);
						gap_nx = $urandom_range(0, 5);
					end else
						burst_nx--;
				end
			end
			gap_left <= gap_nx;
			burst_left <= burst_nx;
		end
	end

	// one long stall of the result side while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_armed <= 1'b1;
		end else if (holdoff_armed && results_seen >= 200) begin
			holdoff_left <= 400;
			holdoff_armed <= 1'b0;
		end else if (holdoff_left > 0)
			holdoff_left <= holdoff_left - 1;
	end

	// monitor: check each result, stall on a random pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want_o = expected_outcomes.pop_front();
					if (m_tdata[31:0] !== want_o.cost)
						report_mismatch("min_cost", m_tdata[31:0], want_o.cost);
					if (m_tdata[32] !== want_o.inf)
						report_mismatch("cost_infinite", m_tdata[32], want_o.inf);
					if (m_tdata[48:33] !== want_o.node)
						report_mismatch("best_node", m_tdata[48:33], want_o.node);
					if (m_tdata[49] !== want_o.nvalid)
						report_mismatch("node_valid", m_tdata[49], want_o.nvalid);
					if (m_tdata[50] !== want_o.added)
						report_mismatch("added", m_tdata[50], want_o.added);
					if (m_tdata[51] !== want_o.full)
						report_mismatch("table_full", m_tdata[51], want_o.full);
					if (m_tdata[56:52] !== want_o.total)
						report_mismatch("entry_total", m_tdata[56:52], want_o.total);
					if (want_o.added)
						adds_stored++;
					if (want_o.full)
						adds_dropped++;
					if (want_o.nvalid)
						queries_finite++;
				end
			end
			m_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= 30);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit reached after %0d results", results_seen);
			$display("subinterval_cost_envelope_table test failed");
			$finish;
		end
	end

	initial begin
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data  <= '0;
		arst_n = 1'b0;
		win_lo = 0;
		win_hi = QMAX;
		tab_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, outside window, fill to full, prune, saturation
		push_req(FUNC_QUERY, 100, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, -5, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_PRUNE, 0, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_NOP, 0, 0, 0, 0, 0, 16'h0);
		for (int i = 0; i < 18; i++)
			push_req(FUNC_ADD, 0, 100 * i, 100 * i + 500, 10000 - 100 * i, 0, 16'(i + 1));
		push_req(FUNC_QUERY, 0, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 50, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 750, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 1000, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 2000, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, -1, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_PRUNE, 900, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 950, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 600, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_ADD, 0, QMIN, QMAX, -100, -1000, 16'hBEEF);
		push_req(FUNC_PRUNE, QMAX, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, 5, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_QUERY, QMAX, 0, 0, 0, 0, 16'h0);
		push_req(FUNC_ADD, 0, QMAX - 10, QMAX, QMAX, QMIN, 16'h1234);
		wait_idle();

		// random mix in the default window, with the long stall
		for (int i = 0; i < 450; i++)
			push_random(1'b0);
		wait_idle();

		// narrower window
		write_cfg(REG_BEGIN, 200);
		write_cfg(REG_END, 3000);
		for (int i = 0; i < 250; i++)
			push_random(1'b0);
		wait_idle();

		// inverted window
		write_cfg(REG_BEGIN, 2000);
		write_cfg(REG_END, 1000);
		for (int i = 0; i < 40; i++)
			push_random(1'b0);
		wait_idle();

		// full range window with extreme values
		write_cfg(REG_BEGIN, QMIN);
		write_cfg(REG_END, QMAX);
		for (int i = 0; i < 230; i++)
			push_random(1'b1);
		wait_idle();
		repeat (5) @(posedge clk);

		$display("%0d requests checked: %0d adds stored, %0d dropped on a full table, %0d queries with a node",
			results_seen, adds_stored, adds_dropped, queries_finite);
		$display("covered empty and full tables, prunes, four windows including an inverted one, and a long output stall");
		if (errors == 0 && expected_outcomes.size() == 0 && results_seen == sent_total)
			$display("subinterval_cost_envelope_table test passed");
		else
			$display("subinterval_cost_envelope_table test failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/scet_pkg.sv
hdl/scet_cell.sv
hdl/scet_eval.sv
hdl/subinterval_cost_envelope_table.sv
verif/tb_subinterval_cost_envelope_table.sv
